@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the checkers of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, quiet while reset is high.
`define CHK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Concurrent check that also holds through reset.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/bir_pkg.sv @@
package bir_pkg;

   localparam int MAX_SRC_ROWS = 512;
   localparam int MAX_SRC_COLS = 512;
   localparam int MAX_CHANNELS = 3;
   localparam int FRAC_BITS    = 16;

   // field widths of the ports
   localparam int POS_W      = 10;
   localparam int SRC_W      = 10;
   localparam int DST_W      = 11;
   localparam int CHN_W      = 2;
   localparam int SMP_W      = 8;
   localparam int STEP_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // four banks by row and column parity
   localparam int NB         = 4;
   localparam int ROWS_HALF  = (MAX_SRC_ROWS + 1) / 2;
   localparam int COLS_HALF  = (MAX_SRC_COLS + 1) / 2;
   localparam int BANK_DEPTH = ROWS_HALF * COLS_HALF * MAX_CHANNELS;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int ADR_CALC_W = 32;

   // arithmetic widths
   localparam int MAP_W = POS_W + STEP_W;
   localparam int INT_W = MAP_W - FRAC_BITS;
   localparam int CMP_W = (INT_W + 1 > 14) ? INT_W + 1 : 14;
   localparam int WGT_W = FRAC_BITS + 1;
   localparam int HOR_W = SMP_W + FRAC_BITS;
   localparam int VER_W = SMP_W + 2 * FRAC_BITS;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_ROWS = 3'd0,
      CSR_SRC_COLS = 3'd1,
      CSR_CHANNELS = 3'd2,
      CSR_DST_ROWS = 3'd3,
      CSR_DST_COLS = 3'd4,
      CSR_ROW_STEP = 3'd5,
      CSR_COL_STEP = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [SRC_W-1:0]  src_rows;
      logic [SRC_W-1:0]  src_cols;
      logic [CHN_W-1:0]  channels;
      logic [DST_W-1:0]  dst_rows;
      logic [DST_W-1:0]  dst_cols;
      logic [STEP_W-1:0] row_step;
      logic [STEP_W-1:0] col_step;
   } cfg_type;

   // one store access, issued to all four banks at once
   typedef struct packed {
      logic                    valid;
      logic                    is_load;
      logic                    err;
      logic [NB-1:0]           wr_bank;
      logic [NB-1:0][AW-1:0]   addr;
      logic [SMP_W-1:0]        sample;
      logic [FRAC_BITS-1:0]    fr;
      logic [FRAC_BITS-1:0]    fc;
      logic                    rpar;
      logic                    cpar;
   } access_type;

   // four neighbours as read, by bank
   typedef struct packed {
      logic                    valid;
      logic                    err;
      logic [NB-1:0][SMP_W-1:0] px;
      logic [FRAC_BITS-1:0]    fr;
      logic [FRAC_BITS-1:0]    fc;
      logic                    rpar;
      logic                    cpar;
   } tap_type;

endpackage

@@ rtl/bir_map.sv @@
module bir_map (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_cmd,
   input  logic [bir_pkg::POS_W-1:0]     req_row_pos,
   input  logic [bir_pkg::POS_W-1:0]     req_col_pos,
   input  logic [bir_pkg::CHN_W-1:0]     req_chan,
   input  logic [bir_pkg::SMP_W-1:0]     req_sample,
   input  bir_pkg::cfg_type              cfg,
   output bir_pkg::access_type           acc
);
   import bir_pkg::*;

   // input stage
   logic              a_valid_ff;
   logic              a_cmd_ff;
   logic [POS_W-1:0]  a_row_ff, a_col_ff;
   logic [CHN_W-1:0]  a_chan_ff;
   logic [SMP_W-1:0]  a_sample_ff;

   // mapped stage
   logic              b_valid_ff;
   logic              b_cmd_ff;
   logic              b_err_ff, b_err_in;
   logic [POS_W-1:0]  b_row_ff, b_col_ff;
   logic [CHN_W-1:0]  b_chan_ff;
   logic [SMP_W-1:0]  b_sample_ff;
   logic [MAP_W-1:0]  b_rmap_ff, b_rmap_in, b_cmap_ff, b_cmap_in;

   access_type        acc_ff, acc_in;

   function automatic logic [INT_W:0] axis_ref(input logic [INT_W-1:0] ip,
                                               input logic [SRC_W-1:0] size,
                                               input logic [CMP_W-1:0] cap);
      logic [CMP_W-1:0] ipx;
      logic [CMP_W-1:0] ip1;
      logic [CMP_W-1:0] szx;
      logic             ok;
      logic [INT_W-1:0] rf;
      ipx = CMP_W'(ip);
      ip1 = ipx + 1'b1;
      szx = CMP_W'(size);
      if (ip1 >= szx) begin
         // reference on the last row or column: step back, keep the delta
         ok = (ip != '0) && (ipx < szx) && (ipx < cap);
         rf = ip - 1'b1;
      end else begin
         ok = ip1 < cap;
         rf = ip;
      end
      return {ok, rf};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_cmd_ff    <= req_cmd;
      a_row_ff    <= req_row_pos;
      a_col_ff    <= req_col_pos;
      a_chan_ff   <= req_chan;
      a_sample_ff <= req_sample;
   end

   always_comb begin
      logic chan_bad;
      logic load_ok;
      b_rmap_in = MAP_W'(a_row_ff) * MAP_W'(cfg.row_step);
      b_cmap_in = MAP_W'(a_col_ff) * MAP_W'(cfg.col_step);
      chan_bad  = (a_chan_ff >= cfg.channels) ||
                  ((CHN_W+1)'(a_chan_ff) >= (CHN_W+1)'(MAX_CHANNELS));
      load_ok   = (a_row_ff < cfg.src_rows) && (a_col_ff < cfg.src_cols) &&
                  (CMP_W'(a_row_ff) < CMP_W'(MAX_SRC_ROWS)) &&
                  (CMP_W'(a_col_ff) < CMP_W'(MAX_SRC_COLS)) && !chan_bad;
      if (a_cmd_ff == CMD_LOAD) begin
         b_err_in = !load_ok;
      end else begin
         b_err_in = (DST_W'(a_row_ff) >= cfg.dst_rows) ||
                    (DST_W'(a_col_ff) >= cfg.dst_cols) || chan_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_cmd_ff    <= a_cmd_ff;
      b_err_ff    <= b_err_in;
      b_row_ff    <= a_row_ff;
      b_col_ff    <= a_col_ff;
      b_chan_ff   <= a_chan_ff;
      b_sample_ff <= a_sample_ff;
      b_rmap_ff   <= b_rmap_in;
      b_cmap_ff   <= b_cmap_in;
   end

   always_comb begin
      logic [INT_W:0]       rres, cres;
      logic [CMP_W-1:0]     rr, cr;
      logic [CMP_W-1:0]     row_ev, row_od, col_ev, col_od;
      logic [CMP_W-1:0]     row_b, col_b;
      logic [ADR_CALC_W-1:0] full;
      rres = axis_ref(b_rmap_ff[MAP_W-1:FRAC_BITS], cfg.src_rows, CMP_W'(MAX_SRC_ROWS));
      cres = axis_ref(b_cmap_ff[MAP_W-1:FRAC_BITS], cfg.src_cols, CMP_W'(MAX_SRC_COLS));
      if (b_cmd_ff == CMD_LOAD) begin
         rr = CMP_W'(b_row_ff);
         cr = CMP_W'(b_col_ff);
         row_ev = rr;
         row_od = rr;
         col_ev = cr;
         col_od = cr;
      end else begin
         rr = CMP_W'(rres[INT_W-1:0]);
         cr = CMP_W'(cres[INT_W-1:0]);
         row_ev = rr[0] ? rr + 1'b1 : rr;
         row_od = rr[0] ? rr : rr + 1'b1;
         col_ev = cr[0] ? cr + 1'b1 : cr;
         col_od = cr[0] ? cr : cr + 1'b1;
      end
      acc_in.valid   = b_valid_ff;
      acc_in.is_load = (b_cmd_ff == CMD_LOAD);
      acc_in.err     = b_err_ff ||
                       ((b_cmd_ff == CMD_COMPUTE) && !(rres[INT_W] && cres[INT_W]));
      acc_in.sample  = b_sample_ff;
      acc_in.fr      = b_rmap_ff[FRAC_BITS-1:0];
      acc_in.fc      = b_cmap_ff[FRAC_BITS-1:0];
      acc_in.rpar    = rr[0];
      acc_in.cpar    = cr[0];
      for (int b = 0; b < NB; b++) begin
         row_b = b[1] ? row_od : row_ev;
         col_b = b[0] ? col_od : col_ev;
         full  = (ADR_CALC_W'(row_b >> 1) * ADR_CALC_W'(COLS_HALF) +
                  ADR_CALC_W'(col_b >> 1)) * ADR_CALC_W'(MAX_CHANNELS) +
                 ADR_CALC_W'(b_chan_ff);
         acc_in.addr[b]    = full[AW-1:0];
         acc_in.wr_bank[b] = b_valid_ff && (b_cmd_ff == CMD_LOAD) && !b_err_ff &&
                             (rr[0] == b[1]) && (cr[0] == b[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff.valid <= 1'b0;
      end else begin
         acc_ff.valid <= acc_in.valid;
      end
      acc_ff.is_load <= acc_in.is_load;
      acc_ff.err     <= acc_in.err;
      acc_ff.wr_bank <= acc_in.wr_bank;
      acc_ff.addr    <= acc_in.addr;
      acc_ff.sample  <= acc_in.sample;
      acc_ff.fr      <= acc_in.fr;
      acc_ff.fc      <= acc_in.fc;
      acc_ff.rpar    <= acc_in.rpar;
      acc_ff.cpar    <= acc_in.cpar;
   end

   assign acc = acc_ff;

endmodule

@@ rtl/bir_store.sv @@
module bir_store (
   input  logic                clock,
   input  logic                reset,
   input  bir_pkg::access_type acc,
   output bir_pkg::tap_type    tap
);
   import bir_pkg::*;

   logic                     valid_ff, valid_in;
   logic                     err_ff;
   logic [FRAC_BITS-1:0]     fr_ff, fc_ff;
   logic                     rpar_ff, cpar_ff;
   logic                     rd_en;

   // loads and computes pass the same stage, so a write always lands
   // before any later read of the same entry
   assign rd_en    = acc.valid && !acc.is_load && !acc.err;
   assign valid_in = acc.valid && !acc.is_load;

   for (genvar b = 0; b < NB; b++) begin : g_bank
      logic [SMP_W-1:0] mem [BANK_DEPTH];
      logic [SMP_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (acc.wr_bank[b]) begin
            mem[acc.addr[b]] <= acc.sample;
         end
         if (rd_en) begin
            rd_ff <= mem[acc.addr[b]];
         end
      end

      assign tap.px[b] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      err_ff  <= acc.err;
      fr_ff   <= acc.fr;
      fc_ff   <= acc.fc;
      rpar_ff <= acc.rpar;
      cpar_ff <= acc.cpar;
   end

   assign tap.valid = valid_ff;
   assign tap.err   = err_ff;
   assign tap.fr    = fr_ff;
   assign tap.fc    = fc_ff;
   assign tap.rpar  = rpar_ff;
   assign tap.cpar  = cpar_ff;

endmodule

@@ rtl/bir_interp.sv @@
module bir_interp (
   input  logic                        clock,
   input  logic                        reset,
   input  bir_pkg::tap_type            tap,
   output logic                        rsp_valid,
   output logic [bir_pkg::SMP_W-1:0]   rsp_pixel_out,
   output logic                        rsp_range_error
);
   import bir_pkg::*;

   localparam int HW1 = HOR_W + 1;
   localparam int VW1 = VER_W + 1;

   logic [SMP_W-1:0]     p00, p01, p10, p11;
   logic [WGT_W-1:0]     wc1, wr1;
   logic [HW1-1:0]       t0, t1, u0, u1;
   logic [HOR_W-1:0]     top_in, bot_in, top_ff, bot_ff;
   logic                 e_valid_ff, e_err_ff;
   logic [FRAC_BITS-1:0] e_fr_ff;
   logic [VW1-1:0]       v0, v1;
   logic [VER_W-1:0]     ver;
   logic                 valid_ff;
   logic                 err_ff;
   logic [SMP_W-1:0]     pixel_ff, pixel_in;

   // map banks back to neighbours by the reference parity
   assign p00 = tap.px[{tap.rpar, tap.cpar}];
   assign p01 = tap.px[{tap.rpar, ~tap.cpar}];
   assign p10 = tap.px[{~tap.rpar, tap.cpar}];
   assign p11 = tap.px[{~tap.rpar, ~tap.cpar}];

   assign wc1 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, tap.fc};

   // horizontal pass along each of the two rows
   always_comb begin
      t0 = HW1'(p00) * HW1'(wc1);
      t1 = HW1'(p01) * HW1'(tap.fc);
      u0 = HW1'(p10) * HW1'(wc1);
      u1 = HW1'(p11) * HW1'(tap.fc);
      top_in = HOR_W'(t0 + t1);
      bot_in = HOR_W'(u0 + u1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= tap.valid;
      end
      e_err_ff <= tap.err;
      e_fr_ff  <= tap.fr;
      top_ff   <= top_in;
      bot_ff   <= bot_in;
   end

   // vertical pass, then drop the fraction bits
   always_comb begin
      wr1 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, e_fr_ff};
      v0  = VW1'(top_ff) * VW1'(wr1);
      v1  = VW1'(bot_ff) * VW1'(e_fr_ff);
      ver = VER_W'(v0 + v1);
      pixel_in = e_err_ff ? '0 : ver[VER_W-1:2*FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= e_valid_ff;
      end
      err_ff   <= e_err_ff;
      pixel_ff <= pixel_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_out   = pixel_ff;
   assign rsp_range_error = err_ff;

endmodule

@@ rtl/bilinear_image_resize.sv @@
// Bilinear image resizer: a banked frame store and a fixed-point resampler.
// Items enter on start while busy is low, with fields req_cmd, req_row_pos,
// req_col_pos, req_chan and req_sample. A load item (req_cmd 0) writes one
// source byte and gives no result; a compute item (req_cmd 1) gives one result
// on rsp_pixel_out and rsp_range_error, marked by rsp_valid for one cycle.
// A compute passes the input, mapped, access, store read, horizontal and output
// registers. One item is accepted every cycle while busy is low; the rate is set
// by the four store banks (row parity x column parity), which serve all four
// neighbours of a compute, or one load, in one access. Items leave in the order
// they came in, loads and computes mixed freely. Registers are written on csr_we
// with csr_index/csr_wdata; the user must write them only while the pipeline is
// empty (unenforced). Reset (synchronous) clears the pipeline and restores the
// register defaults; busy is high while reset is high. Store contents are not
// cleared; the user must read entries only after they were loaded (unenforced).
// The receiver cannot stall, so results flow out at the accepted rate.
module bilinear_image_resize (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_cmd,
   input  logic [bir_pkg::POS_W-1:0]       req_row_pos,
   input  logic [bir_pkg::POS_W-1:0]       req_col_pos,
   input  logic [bir_pkg::CHN_W-1:0]       req_chan,
   input  logic [bir_pkg::SMP_W-1:0]       req_sample,
   output logic                            rsp_valid,
   output logic [bir_pkg::SMP_W-1:0]       rsp_pixel_out,
   output logic                            rsp_range_error,
   input  logic                            csr_we,
   input  logic [bir_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bir_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bir_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   access_type acc;
   tap_type    tap;
   logic       accept;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SRC_ROWS: cfg_in.src_rows = csr_wdata[SRC_W-1:0];
            CSR_SRC_COLS: cfg_in.src_cols = csr_wdata[SRC_W-1:0];
            CSR_CHANNELS: cfg_in.channels = csr_wdata[CHN_W-1:0];
            CSR_DST_ROWS: cfg_in.dst_rows = csr_wdata[DST_W-1:0];
            CSR_DST_COLS: cfg_in.dst_cols = csr_wdata[DST_W-1:0];
            CSR_ROW_STEP: cfg_in.row_step = csr_wdata[STEP_W-1:0];
            CSR_COL_STEP: cfg_in.col_step = csr_wdata[STEP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_rows <= SRC_W'(512);
         cfg_ff.src_cols <= SRC_W'(512);
         cfg_ff.channels <= CHN_W'(3);
         cfg_ff.dst_rows <= DST_W'(512);
         cfg_ff.dst_cols <= DST_W'(512);
         cfg_ff.row_step <= STEP_W'(65536);
         cfg_ff.col_step <= STEP_W'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bir_map u_map (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_cmd     (req_cmd),
      .req_row_pos (req_row_pos),
      .req_col_pos (req_col_pos),
      .req_chan    (req_chan),
      .req_sample  (req_sample),
      .cfg         (cfg_ff),
      .acc         (acc)
   );

   bir_store u_store (
      .clock (clock),
      .reset (reset),
      .acc   (acc),
      .tap   (tap)
   );

   bir_interp u_interp (
      .clock           (clock),
      .reset           (reset),
      .tap             (tap),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_range_error (rsp_range_error)
   );

endmodule

@@ rtl/bir_checker.sv @@
`include "assert_macros.svh"

module bir_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_cmd,
   input logic       rsp_valid,
   input logic [7:0] rsp_pixel_out,
   input logic       rsp_range_error
);

   // a flagged result carries a zero byte
   `CHK_ASSERT(a_err_zero, (rsp_valid && rsp_range_error) |-> (rsp_pixel_out == 8'd0), "error result with nonzero pixel")

   // every accepted compute item yields its result
   `CHK_ASSERT(a_compute_result, (start && !busy && req_cmd) |-> ##6 rsp_valid, "compute item lost")

   // every result traces back to a compute item, never to a load
   `CHK_ASSERT(a_result_source, rsp_valid |-> $past(start && !busy && req_cmd, 6), "result without compute item")

   // the block takes no item while in reset
   `CHK_ASSERT_ALWAYS(a_busy_reset, reset |-> busy, "not busy during reset")

endmodule

bind bilinear_image_resize bir_checker u_bir_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import bir_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int DRAIN_CYCLES = 12;
   localparam int ITEM_TARGET  = 650;

   typedef struct {
      logic               cmd;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [CHN_W-1:0]   chan;
      logic [SMP_W-1:0]   smp;
   } resize_item_type;

   typedef struct {
      logic [SMP_W-1:0]   pixel;
      logic               err;
   } resize_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_cmd = CMD_LOAD;
   logic [POS_W-1:0]       req_row_pos = '0;
   logic [POS_W-1:0]       req_col_pos = '0;
   logic [CHN_W-1:0]       req_chan = '0;
   logic [SMP_W-1:0]       req_sample = '0;
   logic                   rsp_valid;
   logic [SMP_W-1:0]       rsp_pixel_out;
   logic                   rsp_range_error;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bilinear_image_resize i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_row_pos     (req_row_pos),
      .req_col_pos     (req_col_pos),
      .req_chan        (req_chan),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_range_error (rsp_range_error),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // register copy and frame store as the block should hold them
   cfg_type             cfg = '{src_rows: 512, src_cols: 512, channels: 3, dst_rows: 512,
                                dst_cols: 512, row_step: 24'h010000, col_step: 24'h010000};
   logic [SMP_W-1:0]    src_bytes [int];
   bit                  gen_written [int];

   resize_item_type     item_queue [$];
   resize_result_type   pixel_queue [$];

   int                  idle_pct = 19;
   bit                  drain_hold = 1'b0;
   int                  n_items = 0;
   int                  n_taken = 0;
   int                  n_loads = 0;
   int                  n_pixels = 0;
   int                  n_flagged = 0;
   int                  n_settings = 0;
   int                  n_fail = 0;

   function automatic int store_addr(input int r, input int c, input int ch);
      return (r * MAX_SRC_COLS + c) * MAX_CHANNELS + ch;
   endfunction

   function automatic bit load_hits(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                                    input logic [CHN_W-1:0] ch);
      return r < cfg.src_rows && r < MAX_SRC_ROWS && c < cfg.src_cols && c < MAX_SRC_COLS
         && ch < cfg.channels && ch < MAX_CHANNELS;
   endfunction

   // scale one axis; move a reference on the last line back by one, keep its fraction
   function automatic bit map_to_source(input logic [POS_W-1:0] pos,
                                        input logic [STEP_W-1:0] step,
                                        input int unsigned size, input int unsigned cap,
                                        output int base_idx, output logic [FRAC_BITS-1:0] frac);
      longint unsigned p, s, mapped;
      longint base;
      p = pos;
      s = step;
      mapped = p * s;
      base = longint'(mapped >> FRAC_BITS);
      frac = mapped[FRAC_BITS-1:0];
      if (base >= longint'(size) - 1)
         base = base - 1;
      base_idx = int'(base);
      return !(base < 0 || base + 1 >= longint'(size) || base + 1 >= longint'(cap));
   endfunction

   // true when a compute item reads the store; gives the upper-left neighbour
   function automatic bit resample_taps(input logic [POS_W-1:0] rp, input logic [POS_W-1:0] cp,
                                        input logic [CHN_W-1:0] ch, output int r0, output int c0,
                                        output logic [FRAC_BITS-1:0] fr,
                                        output logic [FRAC_BITS-1:0] fc);
      r0 = 0;
      c0 = 0;
      fr = '0;
      fc = '0;
      if (rp >= cfg.dst_rows || cp >= cfg.dst_cols || ch >= cfg.channels || ch >= MAX_CHANNELS)
         return 1'b0;
      if (!map_to_source(rp, cfg.row_step, cfg.src_rows, MAX_SRC_ROWS, r0, fr))
         return 1'b0;
      return map_to_source(cp, cfg.col_step, cfg.src_cols, MAX_SRC_COLS, c0, fc);
   endfunction

   function automatic longint unsigned stored(input int r, input int c, input int ch);
      int a;
      a = store_addr(r, c, ch);
      return src_bytes.exists(a) ? longint'(src_bytes[a]) : 0;
   endfunction

   function automatic resize_result_type predict_resample(input logic [POS_W-1:0] rp,
                                                          input logic [POS_W-1:0] cp,
                                                          input logic [CHN_W-1:0] ch);
      resize_result_type res;
      int r0, c0;
      logic [FRAC_BITS-1:0] fr, fc;
      longint unsigned one, wr, wc, sum;
      res.pixel = '0;
      res.err = 1'b1;
      if (resample_taps(rp, cp, ch, r0, c0, fr, fc)) begin
         one = longint'(1) << FRAC_BITS;
         wr = fr;
         wc = fc;
         sum = stored(r0, c0, ch) * (one - wr) * (one - wc)
             + stored(r0 + 1, c0, ch) * wr * (one - wc)
             + stored(r0, c0 + 1, ch) * (one - wr) * wc
             + stored(r0 + 1, c0 + 1, ch) * wr * wc;
         res.pixel = sum[2*FRAC_BITS +: SMP_W];
         res.err = 1'b0;
      end
      return res;
   endfunction

   // update the store copy or queue the expected pixel for an accepted item
   function automatic void absorb_item(input resize_item_type it);
      resize_result_type res;
      n_taken++;
      if (it.cmd == CMD_LOAD) begin
         n_loads++;
         if (load_hits(it.row, it.col, it.chan))
            src_bytes[store_addr(it.row, it.col, it.chan)] = it.smp;
      end else begin
         res = predict_resample(it.row, it.col, it.chan);
         pixel_queue.push_back(res);
      end
   endfunction

   always @(posedge clock) begin
      bit go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            absorb_item(item_queue.pop_front());
            // hold the next item until the pipeline has drained
            if (n_taken % 97 == 40)
               drain_hold = 1'b1;
         end
         if (drain_hold && pixel_queue.size() == 0)
            drain_hold = 1'b0;
         go = item_queue.size() != 0 && !drain_hold && $urandom_range(99) >= idle_pct;
         if (go) begin
            req_cmd     <= item_queue[0].cmd;
            req_row_pos <= item_queue[0].row;
            req_col_pos <= item_queue[0].col;
            req_chan    <= item_queue[0].chan;
            req_sample  <= item_queue[0].smp;
         end
         start <= go;
      end
   end

   always @(posedge clock) begin
      resize_result_type want;
      if (!reset && rsp_valid) begin
         if (pixel_queue.size() == 0) begin
            n_fail++;
            $display("%0t: unexpected result: expected none, actual pixel %0d error %0b",
                     $time, rsp_pixel_out, rsp_range_error);
         end else begin
            want = pixel_queue.pop_front();
            n_pixels++;
            if (want.err)
               n_flagged++;
            if (rsp_pixel_out !== want.pixel) begin
               n_fail++;
               $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                        $time, want.pixel, rsp_pixel_out);
            end
            if (rsp_range_error !== want.err) begin
               n_fail++;
               $display("%0t: range_error mismatch: expected %0b, actual %0b",
                        $time, want.err, rsp_range_error);
            end
         end
      end
   end

   task automatic push_item(input logic cmd, input logic [POS_W-1:0] r,
                            input logic [POS_W-1:0] c, input logic [CHN_W-1:0] ch,
                            input logic [SMP_W-1:0] smp);
      resize_item_type it;
      it = '{cmd: cmd, row: r, col: c, chan: ch, smp: smp};
      n_items++;
      item_queue.push_back(it);
   endtask

   task automatic add_load(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                           input logic [CHN_W-1:0] ch, input logic [SMP_W-1:0] smp);
      if (load_hits(r, c, ch))
         gen_written[store_addr(r, c, ch)] = 1'b1;
      push_item(CMD_LOAD, r, c, ch, smp);
   endtask

   // load any neighbour not yet written, then issue the compute
   task automatic add_compute(input logic [POS_W-1:0] rp, input logic [POS_W-1:0] cp,
                              input logic [CHN_W-1:0] ch);
      int r0, c0;
      logic [FRAC_BITS-1:0] fr, fc;
      if (resample_taps(rp, cp, ch, r0, c0, fr, fc)) begin
         for (int dr = 0; dr < 2; dr++)
            for (int dc = 0; dc < 2; dc++)
               if (!gen_written.exists(store_addr(r0 + dr, c0 + dc, ch)))
                  add_load(POS_W'(r0 + dr), POS_W'(c0 + dc), ch, SMP_W'($urandom));
      end
      push_item(CMD_COMPUTE, rp, cp, ch, SMP_W'($urandom));
   endtask

   task automatic wait_idle();
      while (item_queue.size() != 0 || pixel_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SRC_ROWS: cfg.src_rows = data[SRC_W-1:0];
         CSR_SRC_COLS: cfg.src_cols = data[SRC_W-1:0];
         CSR_CHANNELS: cfg.channels = data[CHN_W-1:0];
         CSR_DST_ROWS: cfg.dst_rows = data[DST_W-1:0];
         CSR_DST_COLS: cfg.dst_cols = data[DST_W-1:0];
         CSR_ROW_STEP: cfg.row_step = data[STEP_W-1:0];
         CSR_COL_STEP: cfg.col_step = data[STEP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int sr, input int sc, input int ch, input int dr,
                             input int dc, input logic [STEP_W-1:0] rs,
                             input logic [STEP_W-1:0] cs);
      wait_idle();
      csr_write(CSR_SRC_ROWS, CSR_DATA_W'(sr));
      csr_write(CSR_SRC_COLS, CSR_DATA_W'(sc));
      csr_write(CSR_CHANNELS, CSR_DATA_W'(ch));
      csr_write(CSR_DST_ROWS, CSR_DATA_W'(dr));
      csr_write(CSR_DST_COLS, CSR_DATA_W'(dc));
      csr_write(CSR_ROW_STEP, rs);
      csr_write(CSR_COL_STEP, cs);
      // unused index last, so a decode alias would clobber a live register
      csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      n_settings++;
   endtask

   function automatic logic [STEP_W-1:0] pick_step(input int src, input int dst);
      longint s;
      int k;
      k = $urandom_range(9);
      s = (longint'(src) << FRAC_BITS) / dst;
      if (k == 9)
         s = $urandom_range(0, 24'hFFFFFF);
      else if (k >= 7)
         s = s + $urandom_range(0, 255) - 128;
      if (s < 0)
         s = 0;
      if (s > 24'hFFFFFF)
         s = 24'hFFFFFF;
      return s[STEP_W-1:0];
   endfunction

   task automatic random_config();
      int sr, sc, ch, dr, dc;
      sr = ($urandom_range(4) == 0) ? $urandom_range(2, 512) : $urandom_range(2, 12);
      sc = ($urandom_range(4) == 0) ? $urandom_range(2, 512) : $urandom_range(2, 12);
      ch = $urandom_range(1, 3);
      dr = ($urandom_range(4) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 24);
      dc = ($urandom_range(4) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 24);
      set_config(sr, sc, ch, dr, dc, pick_step(sr, dr), pick_step(sc, dc));
   endtask

   task automatic run_random(input int draws);
      int k;
      int unsigned hr, hc;
      repeat (draws) begin
         k = $urandom_range(99);
         hr = (cfg.dst_rows >= 1024) ? 1023 : cfg.dst_rows - 1;
         hc = (cfg.dst_cols >= 1024) ? 1023 : cfg.dst_cols - 1;
         if (k < 55)
            add_compute(POS_W'($urandom_range(hr)), POS_W'($urandom_range(hc)),
                        CHN_W'($urandom_range(cfg.channels - 1)));
         else if (k < 70)
            add_compute(POS_W'($urandom), POS_W'($urandom), CHN_W'($urandom));
         else if (k < 85)
            add_load(POS_W'($urandom_range(cfg.src_rows - 1)),
                     POS_W'($urandom_range(cfg.src_cols - 1)),
                     CHN_W'($urandom_range(cfg.channels - 1)), SMP_W'($urandom));
         else
            add_load(POS_W'($urandom), POS_W'($urandom), CHN_W'($urandom), SMP_W'($urandom));
      end
   endtask

   initial begin
      int phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: corners, move-back at the far edge, every rejected field
      add_load(0, 0, 0, 8'h00);
      add_load(511, 511, 2, 8'hFF);
      add_load(1023, 1023, 3, 8'hA5);
      add_load(512, 7, 0, 8'h5A);
      add_load(5, 5, 3, 8'hC3);
      add_compute(0, 0, 0);
      add_compute(511, 511, 2);
      add_compute(512, 0, 0);
      add_compute(0, 512, 1);
      add_compute(3, 4, 3);

      // 4x4 source, 1.5 row step, fraction just below one on columns
      set_config(4, 4, 2, 8, 8, 24'h018000, 24'h00FFFF);
      add_compute(1, 1, 0);
      add_compute(2, 4, 1);
      add_compute(3, 0, 0);
      add_compute(0, 5, 1);
      add_compute(2, 2, 2);
      add_compute(8, 0, 0);

      set_config(2, 2, 1, 1, 1, 24'h000000, 24'h000000);
      run_random(30);
      set_config(512, 512, 3, 1024, 1024, 24'hFFFFFF, 24'hFFFFFF);
      add_compute(0, 0, 2);
      run_random(30);
      set_config(512, 512, 3, 1024, 1024, 24'h008000, 24'h008000);
      add_compute(1023, 1023, 1);
      run_random(30);

      phase = 0;
      while (n_items < ITEM_TARGET) begin
         random_config();
         idle_pct = (phase == 2) ? 0 : 19;
         run_random(45);
         phase++;
      end

      while (item_queue.size() != 0)
         @(negedge clock);
      for (int i = 0; i < 200 && pixel_queue.size() != 0; i++)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pixel_queue.size() != 0) begin
         n_fail += pixel_queue.size();
         $display("%0t: %0d expected results never arrived", $time, pixel_queue.size());
      end

      $display("covered %0d items: %0d loads, %0d resampled pixels (%0d flagged out of range)",
               n_taken, n_loads, n_pixels, n_flagged);
      $display("across %0d register settings", n_settings);
      if (n_fail == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
